>>> rtl/four_digit_seven_segment_scanner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scanner
// Clocked assertion wrappers, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// checked only outside reset
`define FDSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define FDSS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/fdss_pkg.sv
// ----------------------------------------------------------------------------
// fdss_pkg
// Types, codes and the glyph table for the seven-segment scanner.
// ----------------------------------------------------------------------------
package fdss_pkg;

   // function codes
   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_NUMBER   = 3'd1;
   localparam logic [2:0] FUNC_PROG     = 3'd2;
   localparam logic [2:0] FUNC_CLEAR    = 3'd3;
   localparam logic [2:0] FUNC_DASH     = 3'd4;

   // glyph codes
   localparam logic [4:0] GLYPH_ZERO    = 5'd0;
   localparam logic [4:0] GLYPH_P       = 5'd10;
   localparam logic [4:0] GLYPH_R       = 5'd11;
   localparam logic [4:0] GLYPH_O       = 5'd12;
   localparam logic [4:0] GLYPH_G       = 5'd13;
   localparam logic [4:0] GLYPH_DASH    = 5'd14;
   localparam logic [4:0] GLYPH_C       = 5'd15;
   localparam logic [4:0] GLYPH_L       = 5'd16;
   localparam logic [4:0] GLYPH_BLANK   = 5'd31;

   localparam int NUM_SLOTS = 4;

   typedef logic [4:0] glyph_type;
   typedef glyph_type [NUM_SLOTS-1:0] slots_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] value;
      logic [2:0]  position;
   } req_type;

   typedef struct packed {
      logic [6:0] segments_n;
      logic [3:0] digit_enable;
   } rsp_type;

   // active-low segments a..g in bits 0..6; unknown codes show blank
   function automatic logic [6:0] glyph_to_segments(glyph_type code);
      logic [6:0] seg;
      unique case (code)
         5'd0:        seg = 7'h40;
         5'd1:        seg = 7'h79;
         5'd2:        seg = 7'h24;
         5'd3:        seg = 7'h30;
         5'd4:        seg = 7'h19;
         5'd5:        seg = 7'h12;
         5'd6:        seg = 7'h02;
         5'd7:        seg = 7'h78;
         5'd8:        seg = 7'h00;
         5'd9:        seg = 7'h10;
         GLYPH_P:     seg = 7'h0C;
         GLYPH_R:     seg = 7'h2F;
         GLYPH_O:     seg = 7'h23;
         GLYPH_G:     seg = 7'h10;
         GLYPH_DASH:  seg = 7'h3F;
         GLYPH_C:     seg = 7'h27;
         GLYPH_L:     seg = 7'h47;
         default:     seg = 7'h7F;
      endcase
      return seg;
   endfunction

endpackage

>>> rtl/fdss_glyph_load.sv
// ----------------------------------------------------------------------------
// fdss_glyph_load
// Builds the four glyph slots that a load beat writes.
// ----------------------------------------------------------------------------
module fdss_glyph_load (
   input  fdss_pkg::req_type   item,
   output logic                is_load,
   output fdss_pkg::slots_type slots
);
   import fdss_pkg::*;

   // v / 10^k by reciprocal multiply, exact over the 16-bit range
   logic [31:0] prod1;
   logic [32:0] prod2;
   logic [32:0] prod3;
   logic [32:0] prod4;
   logic [12:0] quot1;
   logic [9:0]  quot2;
   logic [6:0]  quot3;
   logic [2:0]  quot4;
   slots_type   num_slots;

   // x - 10*q, taken mod 16 (true result is below 10)
   function automatic logic [3:0] low_digit(logic [3:0] x, logic [3:0] q);
      return x - ((q << 3) + (q << 1));
   endfunction

   assign prod1 = 32'(item.value) * 32'd52429;
   assign prod2 = 33'(item.value) * 33'd83887;
   assign prod3 = 33'(item.value) * 33'd67109;
   assign prod4 = 33'(item.value) * 33'd107375;
   assign quot1 = prod1[31:19];
   assign quot2 = prod2[32:23];
   assign quot3 = prod3[32:26];
   assign quot4 = prod4[32:30];

   always_comb begin
      num_slots[0] = {1'b0, low_digit(item.value[3:0], quot1[3:0])};
      num_slots[1] = (quot1 == '0) ? GLYPH_BLANK
                                   : {1'b0, low_digit(quot1[3:0], quot2[3:0])};
      num_slots[2] = (quot2 == '0) ? GLYPH_BLANK
                                   : {1'b0, low_digit(quot2[3:0], quot3[3:0])};
      num_slots[3] = (quot3 == '0) ? GLYPH_BLANK
                                   : {1'b0, low_digit(quot3[3:0], {1'b0, quot4})};
   end

   always_comb begin
      is_load = 1'b1;
      slots   = num_slots;
      unique case (item.func)
         FUNC_NUMBER: slots = num_slots;
         FUNC_PROG:   slots = {GLYPH_P, GLYPH_R, GLYPH_O, GLYPH_G};
         FUNC_CLEAR:  slots = {GLYPH_BLANK, GLYPH_C, GLYPH_L, GLYPH_R};
         FUNC_DASH: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               slots[i] = (item.position == 3'(i)) ? GLYPH_DASH : GLYPH_BLANK;
            end
         end
         default: is_load = 1'b0;
      endcase
   end

endmodule

>>> rtl/four_digit_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner
// Four-slot glyph store and scan driver for a multiplexed 7-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per command. A tick beat (func 0) returns one rsp
//   beat with the active-low segments and the one-hot digit enable of the
//   current slot, then advances the scan slot. Load beats (number, "Prog",
//   clear message, dash) rewrite all four slots and return nothing; unused
//   func codes are dropped.
//   csr channel: the display_off bit, always ready. While set, a tick
//   returns all lines low and the scan slot holds. Write it only when idle.
//   Path: a tick beat passes the input register, then the result register,
//   before rsp_valid rises. Throughput: one beat per cycle while rsp is
//   not stalled, set by the single decode/lookup pass between the registers.
//   Stall: a held rsp beat blocks further ticks in the input register,
//   loads still drain; req_ready drops only when the input register holds
//   a tick that cannot move.
//   Reset: slots show the digit zero, scan slot 0, display on, no beats held.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fdss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fdss_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import fdss_pkg::*;

   // input register
   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff, in_data_in;

   // block state
   slots_type glyph_slots_ff, glyph_slots_in;
   logic [1:0] scan_index_ff, scan_index_in;
   logic      display_off_ff, display_off_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic      is_tick;
   logic      out_free;
   logic      in_fire;
   logic      is_load;
   slots_type load_slots;

   fdss_glyph_load u_load (
      .item    (in_data_ff),
      .is_load (is_load),
      .slots   (load_slots)
   );

   assign is_tick   = (in_data_ff.func == FUNC_TICK);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a held beat moves on unless it is a tick facing a full result register
   assign in_fire   = in_valid_ff && (!is_tick || out_free);
   assign req_ready = !in_valid_ff || in_fire;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_data_in     = in_data_ff;
      glyph_slots_in = glyph_slots_ff;
      scan_index_in  = scan_index_ff;
      display_off_in = display_off_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end

      if (csr_valid) begin
         display_off_in = csr_data;
      end

      if (in_fire) begin
         if (is_tick) begin
            rsp_valid_in = 1'b1;
            if (display_off_ff) begin
               rsp_data_in = '0;
            end else begin
               rsp_data_in.segments_n   = glyph_to_segments(glyph_slots_ff[scan_index_ff]);
               rsp_data_in.digit_enable = 4'b1000 >> scan_index_ff;
               scan_index_in            = scan_index_ff + 2'd1;
            end
         end else if (is_load) begin
            glyph_slots_in = load_slots;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         glyph_slots_ff <= {NUM_SLOTS{GLYPH_ZERO}};
         scan_index_ff  <= '0;
         display_off_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         glyph_slots_ff <= glyph_slots_in;
         scan_index_ff  <= scan_index_in;
         display_off_ff <= display_off_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/fdss_checker.sv
// ----------------------------------------------------------------------------
// fdss_checker
// Port-level checks for the seven-segment scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_digit_seven_segment_scanner_defines.svh"

module fdss_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fdss_pkg::rsp_type rsp_data
);
   import fdss_pkg::*;

   // stalled result beat keeps valid and payload
   `FDSS_ASSERT(a_rsp_hold_valid, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped")
   `FDSS_ASSERT(a_rsp_hold_data, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp data changed")

   // a result is either one lit digit or all lines low
   `FDSS_ASSERT(a_rsp_shape,
      rsp_valid |-> ($onehot(rsp_data.digit_enable) ||
                     (rsp_data.digit_enable == 4'd0 && rsp_data.segments_n == 7'd0)),
      "bad digit enable")

   // nothing comes out right after reset
   `FDSS_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind four_digit_seven_segment_scanner fdss_checker u_fdss_checker (.*);
